// File: hdl/jts_pkg.sv
// shared types and constants for the json token scanner
package jts_pkg;

    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COLON    = 4'd4;
    localparam logic [3:0] KIND_COMMA    = 4'd5;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd6;
    localparam logic [3:0] KIND_IDENT    = 4'd7;
    localparam logic [3:0] KIND_INT      = 4'd8;
    localparam logic [3:0] KIND_FLOAT    = 4'd9;
    localparam logic [3:0] KIND_STRING   = 4'd10;
    localparam logic [3:0] KIND_END      = 4'd11;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  out_byte;
        logic        in_text;
        logic        token_first;
        logic        token_last;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        unclosed_string;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } result_pair_t;

endpackage

// File: hdl/jts_if.sv
// stream interfaces for text bytes in and token results out
interface jts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_final;

    modport source (output valid, output text_byte, output is_final, input ready);
    modport sink (input valid, input text_byte, input is_final, output ready);
endinterface

interface jts_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  out_byte;
    logic        in_text;
    logic        token_first;
    logic        token_last;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        unclosed_string;
    logic        run_last;

    modport source (
        output valid,
        output token_kind,
        output out_byte,
        output in_text,
        output token_first,
        output token_last,
        output line_number,
        output column_number,
        output unclosed_string,
        output run_last,
        input  ready
    );
    modport sink (
        input  valid,
        input  token_kind,
        input  out_byte,
        input  in_text,
        input  token_first,
        input  token_last,
        input  line_number,
        input  column_number,
        input  unclosed_string,
        input  run_last,
        output ready
    );
endinterface

// File: hdl/json_token_scanner_unit.sv
// top level of the json token scanner
// Streams JSON text in one byte per transaction and returns one tagged result per
// byte, one byte behind, save whitespace outside strings and a backslash escaping
// a quote, plus an end result when a NUL or a byte marked is_final closes the text.
// A byte is taken into the input register and classified once the output queue has
// room; its results land in that four-entry queue, whose head is offered on the port.
// A new byte is accepted every cycle while the queue holds at most two results; the
// end of a text can yield two results from one byte, and the queue drains one result
// per cycle while token_out.ready is high, so the output port sets the sustained
// rate at one result per cycle.
// Row and column count up to 2**POSITION_WIDTH-1 and hold there; the low 16 bits
// are reported.
module json_token_scanner_unit #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    jts_byte_if.sink           byte_in,
    jts_token_if.source        token_out
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_final_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_next;
    logic                  in_final_next;
    logic                  accept;
    logic                  step;
    logic                  space;
    logic                  head_valid;
    logic                  pop;
    jts_pkg::result_t      head;
    jts_pkg::result_pair_t pair;

    assign step          = in_valid_reg && space;
    assign byte_in.ready = !in_valid_reg || step;
    assign accept        = byte_in.valid && byte_in.ready;
    assign pop           = head_valid && token_out.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_final_next = in_final_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = byte_in.text_byte;
            in_final_next = byte_in.is_final;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        in_final_reg <= in_final_next;
    end

    jts_scan_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (in_byte_reg),
        .is_final  (in_final_reg),
        .pair      (pair)
    );

    jts_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .space      (space)
    );

    assign token_out.valid           = head_valid;
    assign token_out.token_kind      = head.token_kind;
    assign token_out.out_byte        = head.out_byte;
    assign token_out.in_text         = head.in_text;
    assign token_out.token_first     = head.token_first;
    assign token_out.token_last      = head.token_last;
    assign token_out.line_number     = head.line_number;
    assign token_out.column_number   = head.column_number;
    assign token_out.unclosed_string = head.unclosed_string;
    assign token_out.run_last        = head.run_last;

endmodule

// File: hdl/jts_scan_core.sv
// lexer state and per-byte classification, up to two results per byte
module jts_scan_core #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          text_byte,
    input  logic                is_final,
    output jts_pkg::result_pair_t pair
);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_STRING = 2'd3;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    typedef struct packed {
        logic       emit;
        logic [3:0] kind;
        logic       txt;
        logic       first;
        logic       last;
        logic [1:0] mode;
        logic       qd;
        logic       keep;
        logic       seen;
    } class_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic class_t classify(
        input logic [7:0] c,
        input logic       nv,
        input logic [7:0] nx,
        input logic [1:0] mode,
        input logic       qd,
        input logic       keep,
        input logic       seen
    );
        class_t     s;
        logic       go;
        logic       sn;
        logic [7:0] q;
        s.emit  = 1'b1;
        s.kind  = jts_pkg::KIND_UNKNOWN;
        s.txt   = 1'b0;
        s.first = 1'b0;
        s.last  = 1'b0;
        s.mode  = mode;
        s.qd    = qd;
        s.keep  = keep;
        s.seen  = seen;
        q  = qd ? jts_pkg::CH_DQUOTE : jts_pkg::CH_SQUOTE;
        go = 1'b0;
        sn = seen;
        case (mode)
            MODE_IDENT:
            begin
                go     = nv && is_alnum(nx);
                s.kind = jts_pkg::KIND_IDENT;
                s.txt  = 1'b1;
                s.last = !go;
                if (!go)
                begin
                    s.mode = MODE_IDLE;
                end
            end
            MODE_NUMBER:
            begin
                sn     = seen || (c == jts_pkg::CH_DOT);
                go     = nv && (is_alnum(nx) || nx == jts_pkg::CH_MINUS
                                || (nx == jts_pkg::CH_DOT && !sn));
                s.kind = (!go && sn) ? jts_pkg::KIND_FLOAT : jts_pkg::KIND_INT;
                s.txt  = 1'b1;
                s.last = !go;
                s.seen = go ? sn : 1'b0;
                if (!go)
                begin
                    s.mode = MODE_IDLE;
                end
            end
            MODE_STRING:
            begin
                s.kind = jts_pkg::KIND_STRING;
                s.txt  = 1'b1;
                if (keep)
                begin
                    s.keep = 1'b0;
                end
                else if (c == q)
                begin
                    s.mode = MODE_IDLE;
                    s.txt  = 1'b0;
                    s.last = 1'b1;
                end
                else if (c == jts_pkg::CH_BACKSLASH && nv && nx == jts_pkg::CH_BACKSLASH)
                begin
                    s.keep = 1'b1;
                end
                else if (c == jts_pkg::CH_BACKSLASH && nv && nx == q)
                begin
                    s.keep = 1'b1;
                    s.emit = 1'b0;
                end
            end
            default:
            begin
                s.mode = MODE_IDLE;
                if (c inside {jts_pkg::CH_SPACE, jts_pkg::CH_CR, jts_pkg::CH_LF,
                              jts_pkg::CH_TAB})
                begin
                    s.emit = 1'b0;
                end
                else if ((c inside {[8'h30:8'h39]})
                         || (c == jts_pkg::CH_MINUS && nv && is_alnum(nx)))
                begin
                    go      = nv && (is_alnum(nx) || nx == jts_pkg::CH_MINUS
                                     || nx == jts_pkg::CH_DOT);
                    s.seen  = 1'b0;
                    s.kind  = jts_pkg::KIND_INT;
                    s.txt   = 1'b1;
                    s.first = 1'b1;
                    s.last  = !go;
                    if (go)
                    begin
                        s.mode = MODE_NUMBER;
                    end
                end
                else if (is_alnum(c))
                begin
                    go      = nv && is_alnum(nx);
                    s.kind  = jts_pkg::KIND_IDENT;
                    s.txt   = 1'b1;
                    s.first = 1'b1;
                    s.last  = !go;
                    if (go)
                    begin
                        s.mode = MODE_IDENT;
                    end
                end
                else if (c == jts_pkg::CH_DQUOTE || c == jts_pkg::CH_SQUOTE)
                begin
                    s.mode  = MODE_STRING;
                    s.qd    = (c == jts_pkg::CH_DQUOTE);
                    s.keep  = 1'b0;
                    s.kind  = jts_pkg::KIND_STRING;
                    s.first = 1'b1;
                end
                else
                begin
                    s.first = 1'b1;
                    s.last  = 1'b1;
                    case (c)
                        jts_pkg::CH_LBRACE:   s.kind = jts_pkg::KIND_LBRACE;
                        jts_pkg::CH_RBRACE:   s.kind = jts_pkg::KIND_RBRACE;
                        jts_pkg::CH_LBRACKET: s.kind = jts_pkg::KIND_LBRACKET;
                        jts_pkg::CH_RBRACKET: s.kind = jts_pkg::KIND_RBRACKET;
                        jts_pkg::CH_COLON:    s.kind = jts_pkg::KIND_COLON;
                        jts_pkg::CH_COMMA:    s.kind = jts_pkg::KIND_COMMA;
                        default:              s.kind = jts_pkg::KIND_UNKNOWN;
                    endcase
                end
            end
        endcase
        return s;
    endfunction

    logic [7:0]                held_byte_reg;
    logic                      held_valid_reg;
    logic [1:0]                mode_reg;
    logic                      qd_reg;
    logic                      keep_reg;
    logic                      seen_reg;
    logic [POSITION_WIDTH-1:0] row_reg;
    logic [POSITION_WIDTH-1:0] col_reg;
    logic                      pend_reg;
    logic                      pend_unc_reg;
    logic [15:0]               pend_row_reg;
    logic [15:0]               pend_col_reg;

    logic [7:0]                held_byte_next;
    logic                      held_valid_next;
    logic [1:0]                mode_next;
    logic                      qd_next;
    logic                      keep_next;
    logic                      seen_next;
    logic [POSITION_WIDTH-1:0] row_next;
    logic [POSITION_WIDTH-1:0] col_next;
    logic                      pend_next;
    logic                      pend_unc_next;
    logic [15:0]               pend_row_next;
    logic [15:0]               pend_col_next;

    logic                      is_nul;
    logic                      end_now;
    logic                      do_b;
    class_t                    ca;
    class_t                    cb;
    logic [1:0]                mode_m;
    logic                      qd_m;
    logic                      keep_m;
    logic                      seen_m;
    logic [1:0]                mode_f;
    logic [POSITION_WIDTH-1:0] row_inc;
    logic [POSITION_WIDTH-1:0] col_inc;
    logic [POSITION_WIDTH-1:0] nr;
    logic [POSITION_WIDTH-1:0] nc;
    logic [POSITION_WIDTH-1:0] end_row;
    logic [POSITION_WIDTH-1:0] end_col;
    logic                      a_p;
    logic                      b_p;
    logic                      x_p;
    jts_pkg::result_t          rp;
    jts_pkg::result_t          ra;
    jts_pkg::result_t          rb;
    jts_pkg::result_t          re;
    jts_pkg::result_t          rx;
    jts_pkg::result_t          slot0;
    jts_pkg::result_t          slot1;
    logic                      slot0_v;
    logic                      slot1_v;

    always_comb
    begin
        is_nul  = (text_byte == jts_pkg::CH_NUL);
        end_now = is_nul || is_final;
        do_b    = !is_nul && is_final;

        // held byte, with the new byte as lookahead
        ca  = classify(held_byte_reg, !is_nul, text_byte, mode_reg, qd_reg, keep_reg,
                       seen_reg);
        a_p = held_valid_reg && ca.emit;
        mode_m = held_valid_reg ? ca.mode : mode_reg;
        qd_m   = held_valid_reg ? ca.qd   : qd_reg;
        keep_m = held_valid_reg ? ca.keep : keep_reg;
        seen_m = held_valid_reg ? ca.seen : seen_reg;

        // final byte flushed with no lookahead
        cb  = classify(text_byte, 1'b0, jts_pkg::CH_NUL, mode_m, qd_m, keep_m, seen_m);
        b_p = do_b && cb.emit;
        mode_f = do_b ? cb.mode : mode_m;

        row_inc = (row_reg == POS_MAX) ? row_reg : row_reg + 1'b1;
        col_inc = (col_reg == POS_MAX) ? col_reg : col_reg + 1'b1;
        if (!held_valid_reg)
        begin
            nr = '0;
            nc = '0;
        end
        else if (text_byte == jts_pkg::CH_LF || text_byte == jts_pkg::CH_CR)
        begin
            nr = row_inc;
            nc = '0;
        end
        else
        begin
            nr = row_reg;
            nc = col_inc;
        end
        end_row = is_nul ? row_reg : nr;
        end_col = is_nul ? (held_valid_reg ? col_inc : col_reg) : nc;

        rp.token_kind      = jts_pkg::KIND_END;
        rp.out_byte        = jts_pkg::CH_NUL;
        rp.in_text         = 1'b0;
        rp.token_first     = 1'b1;
        rp.token_last      = 1'b1;
        rp.line_number     = pend_row_reg;
        rp.column_number   = pend_col_reg;
        rp.unclosed_string = pend_unc_reg;
        rp.run_last        = 1'b0;

        ra.token_kind      = ca.kind;
        ra.out_byte        = held_byte_reg;
        ra.in_text         = ca.txt;
        ra.token_first     = ca.first;
        ra.token_last      = ca.last;
        ra.line_number     = 16'(row_reg);
        ra.column_number   = 16'(col_reg);
        ra.unclosed_string = 1'b0;
        ra.run_last        = 1'b0;

        rb.token_kind      = cb.kind;
        rb.out_byte        = text_byte;
        rb.in_text         = cb.txt;
        rb.token_first     = cb.first;
        rb.token_last      = cb.last;
        rb.line_number     = 16'(nr);
        rb.column_number   = 16'(nc);
        rb.unclosed_string = 1'b0;
        rb.run_last        = 1'b0;

        re.token_kind      = jts_pkg::KIND_END;
        re.out_byte        = jts_pkg::CH_NUL;
        re.in_text         = 1'b0;
        re.token_first     = 1'b1;
        re.token_last      = 1'b1;
        re.line_number     = 16'(end_row);
        re.column_number   = 16'(end_col);
        re.unclosed_string = (mode_f == MODE_STRING);
        re.run_last        = 1'b0;

        // pending end and held byte never occur together
        x_p = pend_reg || a_p;
        rx  = pend_reg ? rp : ra;

        slot0_v = x_p || b_p || end_now;
        slot1_v = (x_p && (b_p || end_now)) || (b_p && end_now);
        slot0   = x_p ? rx : (b_p ? rb : re);
        slot1   = (x_p && b_p) ? rb : re;
        slot0.run_last = !slot1_v;
        slot1.run_last = 1'b1;

        pair.first_valid  = step && slot0_v;
        pair.second_valid = step && slot1_v;
        pair.first        = slot0;
        pair.second       = slot1;

        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        mode_next       = mode_reg;
        qd_next         = qd_reg;
        keep_next       = keep_reg;
        seen_next       = seen_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        pend_next       = pend_reg;
        pend_unc_next   = pend_unc_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        if (step)
        begin
            // end result overflows into the next transaction
            pend_next     = x_p && b_p && end_now;
            pend_unc_next = re.unclosed_string;
            pend_row_next = re.line_number;
            pend_col_next = re.column_number;
            if (end_now)
            begin
                held_valid_next = 1'b0;
                mode_next       = MODE_IDLE;
                qd_next         = 1'b0;
                keep_next       = 1'b0;
                seen_next       = 1'b0;
                row_next        = '0;
                col_next        = '0;
            end
            else
            begin
                held_byte_next  = text_byte;
                held_valid_next = 1'b1;
                mode_next       = mode_m;
                qd_next         = qd_m;
                keep_next       = keep_m;
                seen_next       = seen_m;
                row_next        = nr;
                col_next        = nc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            mode_reg       <= MODE_IDLE;
            qd_reg         <= 1'b0;
            keep_reg       <= 1'b0;
            seen_reg       <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_unc_reg   <= 1'b0;
            pend_row_reg   <= '0;
            pend_col_reg   <= '0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            mode_reg       <= mode_next;
            qd_reg         <= qd_next;
            keep_reg       <= keep_next;
            seen_reg       <= seen_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            pend_reg       <= pend_next;
            pend_unc_reg   <= pend_unc_next;
            pend_row_reg   <= pend_row_next;
            pend_col_reg   <= pend_col_next;
        end
    end

endmodule

// File: hdl/jts_result_fifo.sv
// four-entry compacting result queue, two pushes and one pop per cycle
module jts_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jts_pkg::result_pair_t pair,
    input  logic                  pop,
    output logic                  head_valid,
    output jts_pkg::result_t      head,
    output logic                  space
);

    localparam int DEPTH = 4;

    jts_pkg::result_t entry_reg [DEPTH];
    jts_pkg::result_t entry_next [DEPTH];
    logic [2:0]       count_reg;
    logic [2:0]       count_next;
    logic [2:0]       cnt_pop;
    logic [2:0]       second_idx;

    assign head_valid = (count_reg != 3'd0);
    assign head       = entry_reg[0];
    assign space      = (count_reg <= 3'd2);

    always_comb
    begin
        cnt_pop    = count_reg - 3'(pop);
        second_idx = cnt_pop + 3'(pair.first_valid);
        entry_next = entry_reg;
        if (pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                entry_next[i] = entry_reg[i + 1];
            end
        end
        if (pair.first_valid)
        begin
            entry_next[cnt_pop[1:0]] = pair.first;
        end
        if (pair.second_valid)
        begin
            entry_next[second_idx[1:0]] = pair.second;
        end
        count_next = cnt_pop + 3'(pair.first_valid) + 3'(pair.second_valid);
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: tb/json_token_scanner_unit_test.sv
// self-checking testbench for json_token_scanner_unit: byte stream in, token results checked
module json_token_scanner_unit_test;
    import jts_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int POSITION_WIDTH = 16;
    localparam int unsigned POSITION_MAX = (1 << POSITION_WIDTH) - 1;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_TAIL = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_PRINTED = 100;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_STRING
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    jts_byte_if byte_bus();
    jts_token_if token_bus();

    json_token_scanner_unit #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .byte_in(byte_bus),
        .token_out(token_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // scanner state mirrored by the predictor
    logic [7:0]  held_ch = CH_NUL;
    logic        held_ok = 1'b0;
    scan_mode_t  scan_mode = SCAN_IDLE;
    logic        quote_double = 1'b0;
    logic        keep_escaped = 1'b0;
    logic        dot_seen = 1'b0;
    int unsigned line_pos = 0;
    int unsigned col_pos = 0;
    logic        end_waiting = 1'b0;
    logic        end_open = 1'b0;
    int unsigned end_line = 0;
    int unsigned end_col = 0;

    result_t    call_results[$];
    result_t    expected_tokens[$];
    text_item_t pending_items[$];
    text_item_t next_item;

    logic [7:0] punct_chars[6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET,
                                   CH_RBRACKET, CH_COLON, CH_COMMA};
    logic [7:0] blank_chars[4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    int mismatch_count = 0;
    int sent_count = 0;
    int received_count = 0;
    int result_index = 0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic int unsigned bump_position(input int unsigned v);
        return (v >= POSITION_MAX) ? POSITION_MAX : v + 1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic number_continues(input logic nv, input logic [7:0] nx);
        return nv && (is_alnum(nx) || nx == CH_MINUS || (nx == CH_DOT && !dot_seen));
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        case (c)
            CH_LBRACE:   return KIND_LBRACE;
            CH_RBRACE:   return KIND_RBRACE;
            CH_LBRACKET: return KIND_LBRACKET;
            CH_RBRACKET: return KIND_RBRACKET;
            CH_COLON:    return KIND_COLON;
            CH_COMMA:    return KIND_COMMA;
            default:     return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic logic [7:0] random_alnum();
        case ($urandom_range(0, 2))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return 8'("A" + $urandom_range(0, 25));
            default: return 8'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    task automatic emit_token(input logic [3:0] kind, input logic [7:0] ch, input logic txt,
                              input logic is_first, input logic is_last,
                              input int unsigned row, input int unsigned col,
                              input logic unc);
        result_t r;
        r.token_kind = kind;
        r.out_byte = ch;
        r.in_text = txt;
        r.token_first = is_first;
        r.token_last = is_last;
        r.line_number = row[15:0];
        r.column_number = col[15:0];
        r.unclosed_string = unc;
        r.run_last = 1'b0;
        call_results.push_back(r);
    endtask

    task automatic classify_held(input logic [7:0] c, input logic nv, input logic [7:0] nx);
        int unsigned r;
        int unsigned k;
        logic go;
        logic [7:0] q;
        r = line_pos;
        k = col_pos;
        case (scan_mode)
            SCAN_IDENT:
            begin
                go = nv && is_alnum(nx);
                if (!go)
                    scan_mode = SCAN_IDLE;
                emit_token(KIND_IDENT, c, 1'b1, 1'b0, !go, r, k, 1'b0);
            end
            SCAN_NUMBER:
            begin
                if (c == CH_DOT)
                    dot_seen = 1'b1;
                go = number_continues(nv, nx);
                emit_token((!go && dot_seen) ? KIND_FLOAT : KIND_INT, c, 1'b1, 1'b0, !go,
                           r, k, 1'b0);
                if (!go)
                begin
                    scan_mode = SCAN_IDLE;
                    dot_seen = 1'b0;
                end
            end
            SCAN_STRING:
            begin
                q = quote_double ? CH_DQUOTE : CH_SQUOTE;
                if (keep_escaped)
                begin
                    keep_escaped = 1'b0;
                    emit_token(KIND_STRING, c, 1'b1, 1'b0, 1'b0, r, k, 1'b0);
                end
                else if (c == q)
                begin
                    scan_mode = SCAN_IDLE;
                    emit_token(KIND_STRING, c, 1'b0, 1'b0, 1'b1, r, k, 1'b0);
                end
                else if (c == CH_BACKSLASH && nv && nx == CH_BACKSLASH)
                begin
                    keep_escaped = 1'b1;
                    emit_token(KIND_STRING, c, 1'b1, 1'b0, 1'b0, r, k, 1'b0);
                end
                else if (c == CH_BACKSLASH && nv && nx == q)
                    keep_escaped = 1'b1;
                else
                    emit_token(KIND_STRING, c, 1'b1, 1'b0, 1'b0, r, k, 1'b0);
            end
            default:
            begin
                if (c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB)
                    scan_mode = SCAN_IDLE;
                else if (is_digit(c) || (c == CH_MINUS && nv && is_alnum(nx)))
                begin
                    dot_seen = 1'b0;
                    go = number_continues(nv, nx);
                    if (go)
                        scan_mode = SCAN_NUMBER;
                    emit_token(KIND_INT, c, 1'b1, 1'b1, !go, r, k, 1'b0);
                end
                else if (is_alnum(c))
                begin
                    go = nv && is_alnum(nx);
                    if (go)
                        scan_mode = SCAN_IDENT;
                    emit_token(KIND_IDENT, c, 1'b1, 1'b1, !go, r, k, 1'b0);
                end
                else if (c == CH_DQUOTE || c == CH_SQUOTE)
                begin
                    scan_mode = SCAN_STRING;
                    quote_double = (c == CH_DQUOTE);
                    keep_escaped = 1'b0;
                    emit_token(KIND_STRING, c, 1'b0, 1'b1, 1'b0, r, k, 1'b0);
                end
                else
                    emit_token(punct_kind(c), c, 1'b0, 1'b1, 1'b1, r, k, 1'b0);
            end
        endcase
    endtask

    // an end result that would be third in one transaction waits for the next one
    task automatic end_text();
        logic unc;
        unc = (scan_mode == SCAN_STRING);
        if (call_results.size() < 2)
            emit_token(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, line_pos, col_pos, unc);
        else
        begin
            end_waiting = 1'b1;
            end_open = unc;
            end_line = line_pos;
            end_col = col_pos;
        end
        held_ch = CH_NUL;
        held_ok = 1'b0;
        scan_mode = SCAN_IDLE;
        quote_double = 1'b0;
        keep_escaped = 1'b0;
        dot_seen = 1'b0;
        line_pos = 0;
        col_pos = 0;
    endtask

    task automatic predict_results(input logic [7:0] b, input logic fin);
        int unsigned nr;
        int unsigned nc;
        result_t tail;
        call_results.delete();
        if (end_waiting)
        begin
            emit_token(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1, end_line, end_col, end_open);
            end_waiting = 1'b0;
        end
        if (b == CH_NUL)
        begin
            if (held_ok)
            begin
                classify_held(held_ch, 1'b0, CH_NUL);
                col_pos = bump_position(col_pos);
            end
            end_text();
        end
        else
        begin
            nr = 0;
            nc = 0;
            if (held_ok)
            begin
                if (b == CH_LF || b == CH_CR)
                begin
                    nr = bump_position(line_pos);
                    nc = 0;
                end
                else
                begin
                    nr = line_pos;
                    nc = bump_position(col_pos);
                end
                classify_held(held_ch, 1'b1, b);
            end
            held_ch = b;
            held_ok = 1'b1;
            line_pos = nr;
            col_pos = nc;
            if (fin)
            begin
                classify_held(held_ch, 1'b0, CH_NUL);
                end_text();
            end
        end
        if (call_results.size() > 0)
        begin
            tail = call_results.pop_back();
            tail.run_last = 1'b1;
            call_results.push_back(tail);
        end
        foreach (call_results[i])
            expected_tokens.push_back(call_results[i]);
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      result_index, name, got, want));
    endtask

    task automatic check_token();
        result_t want;
        if (expected_tokens.size() == 0)
            report_mismatch($sformatf("result %0d: kind %0d byte %0h with nothing expected",
                                      result_index, token_bus.token_kind,
                                      token_bus.out_byte));
        else
        begin
            want = expected_tokens.pop_front();
            check_field("token_kind", 16'(token_bus.token_kind), 16'(want.token_kind));
            check_field("out_byte", 16'(token_bus.out_byte), 16'(want.out_byte));
            check_field("in_text", 16'(token_bus.in_text), 16'(want.in_text));
            check_field("token_first", 16'(token_bus.token_first),
                        16'(want.token_first));
            check_field("token_last", 16'(token_bus.token_last), 16'(want.token_last));
            check_field("line_number", token_bus.line_number, want.line_number);
            check_field("column_number", token_bus.column_number, want.column_number);
            check_field("unclosed_string", 16'(token_bus.unclosed_string),
                        16'(want.unclosed_string));
            check_field("run_last", 16'(token_bus.run_last), 16'(want.run_last));
        end
        result_index++;
    endtask

    task automatic push_item(input logic [7:0] ch, input logic fin);
        text_item_t t;
        t.ch = ch;
        t.fin = fin;
        pending_items.push_back(t);
    endtask

    task automatic push_text(input string s, input logic fin_last);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], fin_last && (i == s.len() - 1));
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_bus.valid <= 1'b0;
            byte_bus.text_byte <= CH_NUL;
            byte_bus.is_final <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (byte_bus.valid && byte_bus.ready)
            begin
                predict_results(byte_bus.text_byte, byte_bus.is_final);
                sent_count++;
            end
            if (!byte_bus.valid || byte_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    byte_bus.valid <= 1'b0;
                end
                else if (pending_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 2);
                    byte_bus.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    next_item = pending_items.pop_front();
                    byte_bus.valid <= 1'b1;
                    byte_bus.text_byte <= next_item.ch;
                    byte_bus.is_final <= next_item.fin;
                end
                else
                    byte_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_bus.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (token_bus.valid && token_bus.ready)
            begin
                check_token();
                received_count++;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                token_bus.ready <= 1'b0;
            end
            else if (pending_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 2);
                token_bus.ready <= 1'b0;
            end
            else
                token_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        int random_start;
        int tokens;
        int len;
        int seen_count;
        int quiet_cycles;
        logic [7:0] q;
        text_item_t tail;

        // empty text
        push_item(CH_NUL, 1'b0);
        // punctuation, escaped quote, doubled backslash, number with a dot, identifier
        push_text("[{\"\\\"\\\\\":-7.Z,ab}", 1'b0);
        push_item(CH_TAB, 1'b0);
        push_item(CH_CR, 1'b0);
        push_item(CH_LF, 1'b0);
        // second dot, stray high byte, trailing minus on the final byte
        push_text("1.2.", 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(CH_MINUS, 1'b1);
        // string left open by a NUL
        push_text("'x", 1'b0);
        push_item(CH_NUL, 1'b0);

        random_start = pending_items.size();
        while (pending_items.size() - random_start < RANDOM_ITEMS)
        begin
            tokens = $urandom_range(1, 10);
            for (int t = 0; t < tokens; t++)
            begin
                case ($urandom_range(0, 6))
                    0:
                        push_item(punct_chars[$urandom_range(0, 5)], 1'b0);
                    1:
                    begin
                        len = $urandom_range(1, 6);
                        for (int i = 0; i < len; i++)
                            push_item(random_alnum(), 1'b0);
                    end
                    2:
                    begin
                        if ($urandom_range(0, 2) == 0)
                        begin
                            push_item(CH_MINUS, 1'b0);
                            push_item(random_alnum(), 1'b0);
                        end
                        else
                            push_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                        len = $urandom_range(0, 5);
                        for (int i = 0; i < len; i++)
                        begin
                            case ($urandom_range(0, 5))
                                0, 1:    push_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                                2:       push_item(random_alnum(), 1'b0);
                                3:       push_item(CH_MINUS, 1'b0);
                                default: push_item(CH_DOT, 1'b0);
                            endcase
                        end
                    end
                    3, 4:
                    begin
                        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                        push_item(q, 1'b0);
                        len = $urandom_range(0, 8);
                        for (int i = 0; i < len; i++)
                        begin
                            case ($urandom_range(0, 11))
                                0:
                                begin
                                    push_item(CH_BACKSLASH, 1'b0);
                                    push_item(q, 1'b0);
                                end
                                1:
                                begin
                                    push_item(CH_BACKSLASH, 1'b0);
                                    push_item(CH_BACKSLASH, 1'b0);
                                end
                                2:       push_item(CH_BACKSLASH, 1'b0);
                                3:       push_item((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
                                4:       push_item(8'($urandom_range(128, 255)), 1'b0);
                                5:       push_item(blank_chars[$urandom_range(0, 3)], 1'b0);
                                default: push_item(8'($urandom_range(32, 126)), 1'b0);
                            endcase
                        end
                        if ($urandom_range(0, 4) != 0)
                            push_item(q, 1'b0);
                    end
                    5:
                    begin
                        len = $urandom_range(1, 3);
                        for (int i = 0; i < len; i++)
                            push_item(blank_chars[$urandom_range(0, 3)], 1'b0);
                    end
                    default:
                        push_item(8'($urandom_range(1, 255)), 1'b0);
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    tail = pending_items.pop_back();
                    tail.fin = 1'b1;
                    pending_items.push_back(tail);
                end
                6, 7, 8:
                    push_item(CH_NUL, 1'($urandom_range(0, 1)));
                default:
                begin
                    push_item(CH_DQUOTE, 1'b0);
                    push_item(random_alnum(), 1'b0);
                    push_item(CH_NUL, 1'b0);
                end
            endcase
        end
        // releases an end result still waiting
        push_item(CH_NUL, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        seen_count = 0;
        quiet_cycles = 0;
        while ((pending_items.size() != 0 || byte_bus.valid || expected_tokens.size() != 0)
               && quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if (sent_count + received_count != seen_count)
            begin
                seen_count = sent_count + received_count;
                quiet_cycles = 0;
            end
            else
                quiet_cycles++;
        end
        if (quiet_cycles < STALL_LIMIT)
            repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_tokens.size()));

        if (quiet_cycles < STALL_LIMIT && mismatch_count == 0)
            $display("[json_token_scanner_unit] OK");
        else
            $display("[json_token_scanner_unit] ERROR");
        $finish;
    end

endmodule
